// ===== hw/rtl/pfr_pkg.sv =====
// Shared types, constants and helpers for the Pareto front ranker.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package pfr_pkg;

    localparam int MAX_POPULATION = 64;
    localparam int MAX_OBJECTIVES = 4;
    localparam int IDX_W          = $clog2(MAX_POPULATION);
    localparam int CNT_W          = IDX_W + 1;
    localparam int OBJ_W          = 32;
    localparam int VEC_W          = OBJ_W * MAX_OBJECTIVES;
    localparam int OCNT_W         = 3;
    localparam logic [CNT_W-1:0] RANK_LIMIT = CNT_W'(64);

    typedef logic [VEC_W-1:0] obj_vec_t;

    // Result of one pairwise test
    typedef struct packed {
        logic p_dom_q;
        logic q_dom_p;
    } dom_pair_t;

    // Objective count with zero taken as one and saturation at the maximum
    function automatic logic [OCNT_W-1:0] used_objectives(input logic [OCNT_W-1:0] oc);
        logic [OCNT_W-1:0] k;
        k = oc;
        if (k == '0)
            k = OCNT_W'(1);
        if (k > OCNT_W'(MAX_OBJECTIVES))
            k = OCNT_W'(MAX_OBJECTIVES);
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_if.sv =====
// Channel interfaces for the Pareto front ranker: input, result, config.
// Depends on pfr_pkg.
`default_nettype none

interface pfr_in_if;
    import pfr_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [31:0] objective_a;
    logic signed [31:0] objective_b;
    logic signed [31:0] objective_c;
    logic signed [31:0] objective_d;
    logic               final_member;
    modport source (output valid, objective_a, objective_b, objective_c, objective_d,
                    final_member, input ready);
    modport sink (input valid, objective_a, objective_b, objective_c, objective_d,
                  final_member, output ready);
endinterface

interface pfr_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] member_index;
    logic [6:0] front_rank;
    logic       last_result;
    modport source (output valid, member_index, front_rank, last_result, input ready);
    modport sink (input valid, member_index, front_rank, last_result, output ready);
endinterface

interface pfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] objective_count;
    modport source (output valid, objective_count, input ready);
    modport sink (input valid, objective_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfr_dom_cmp.sv =====
// Pairwise Pareto dominance test over the first k objectives (minimization).
// Depends on pfr_pkg.
`default_nettype none

module pfr_dom_cmp
    import pfr_pkg::*;
(
    input  wire obj_vec_t          vec_p,
    input  wire obj_vec_t          vec_q,
    input  wire logic [OCNT_W-1:0] k,
    output dom_pair_t              result
);

    logic [MAX_OBJECTIVES-1:0] p_less;
    logic [MAX_OBJECTIVES-1:0] q_less;

    // Per-objective signed compares, unused objectives masked off
    always_comb
    begin
        for (int m = 0; m < MAX_OBJECTIVES; m++)
        begin
            if (OCNT_W'(m) < k)
            begin
                p_less[m] = $signed(vec_p[m*OBJ_W +: OBJ_W]) < $signed(vec_q[m*OBJ_W +: OBJ_W]);
                q_less[m] = $signed(vec_q[m*OBJ_W +: OBJ_W]) < $signed(vec_p[m*OBJ_W +: OBJ_W]);
            end
            else
            begin
                p_less[m] = 1'b0;
                q_less[m] = 1'b0;
            end
        end
    end

    assign result.p_dom_q = (|p_less) && !(|q_less);
    assign result.q_dom_p = (|q_less) && !(|p_less);

endmodule

`default_nettype wire

// ===== hw/rtl/pareto_front_ranker.sv =====
// Pareto front ranker top level: load, pairwise compare, front peeling, output.
// Depends on pfr_pkg, pfr_if.sv interfaces and pfr_dom_cmp.
//
// Usage:
//   in_ch  : one word per individual (four signed objectives, final_member).
//            final_member closes the population and starts ranking. Words past
//            64 individuals are dropped; a dropped final word still closes.
//   out_ch : one word per individual in load order (member_index, front_rank),
//            last_result set on the final one.
//   cfg_ch : objective_count, always ready; write only while idle.
// Timing: loading takes one word per cycle. Ranking first runs the compares
//   (one pair per cycle through the two read ports of the objective memory),
//   then peels the fronts (one row of the dominance memory per cycle), then
//   sends the results.
// in_ch.ready is low from the final word until the last result is loaded into
// the output register; the next population may start loading while that word
// still waits to be taken.
// Reset clears the population and sets objective_count to 2; no memory
// clearing pass is needed. A stalled receiver simply holds the output
// register; the result sequence resumes when it is taken.
`default_nettype none

module pareto_front_ranker
    import pfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    pfr_in_if.sink       in_ch,
    pfr_out_if.source    out_ch,
    pfr_cfg_if.sink      cfg_ch
);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_CMP      = 3'd1;
    localparam logic [2:0] ST_CMP_END  = 3'd2;
    localparam logic [2:0] ST_PEEL     = 3'd3;
    localparam logic [2:0] ST_PEEL_END = 3'd4;
    localparam logic [2:0] ST_OUT      = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [OCNT_W-1:0]   ocount_reg;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_q_reg;
    logic [MAX_POPULATION-1:0] row_reg, row_upd;
    logic [CNT_W-1:0]    cnt_reg, cnt_upd;
    logic                peel_valid_reg;
    logic [MAX_POPULATION-1:0] front_reg, next_acc_reg, new_bits;
    logic [CNT_W-1:0]    rank_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic [CNT_W-1:0]    out_rank_reg;
    logic                out_last_reg;

    // Memories and cells
    obj_vec_t                  obj_mem [MAX_POPULATION];
    logic [MAX_POPULATION-1:0] row_mem [MAX_POPULATION];
    obj_vec_t                  obj_p_q, obj_q_q;
    logic [MAX_POPULATION-1:0] row_q;
    logic [CNT_W-1:0]          cnt_cell_reg [MAX_POPULATION];
    logic [CNT_W-1:0]          rank_cell_reg [MAX_POPULATION];

    dom_pair_t                 dom;
    logic                      in_acc, out_take, q_last, n_full, out_last_idx;

    assign in_acc       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_LOAD);
    assign cfg_ch.ready = 1'b1;
    assign out_take     = !out_valid_reg || out_ch.ready;
    assign q_last       = ({1'b0, q_reg} == n_reg - CNT_W'(1));
    assign out_last_idx = ({1'b0, out_idx_reg} == n_reg - CNT_W'(1));
    assign n_full       = (loaded_reg == CNT_W'(MAX_POPULATION));

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ocount_reg <= OCNT_W'(2);
        else if (cfg_ch.valid && cfg_ch.ready)
            ocount_reg <= cfg_ch.objective_count;
    end

    // Objective memory: write on load, two registered reads for the pair
    always_ff @(posedge clk)
    begin
        if (in_acc && !n_full)
            obj_mem[loaded_reg[IDX_W-1:0]] <= {in_ch.objective_d, in_ch.objective_c,
                                               in_ch.objective_b, in_ch.objective_a};
        obj_p_q <= obj_mem[p_reg];
        obj_q_q <= obj_mem[q_reg];
    end

    pfr_dom_cmp u_cmp (
        .vec_p  (obj_p_q),
        .vec_q  (obj_q_q),
        .k      (used_objectives(ocount_reg)),
        .result (dom)
    );

    // Row and dominator count for the current p
    always_comb
    begin
        row_upd = row_reg;
        cnt_upd = cnt_reg;
        if (cmp_valid_reg)
        begin
            if (dom.p_dom_q)
                row_upd[cmp_q_reg] = 1'b1;
            else if (dom.q_dom_p)
                cnt_upd = cnt_reg + CNT_W'(1);
        end
    end

    // Dominance row memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP_END)
            row_mem[p_reg] <= row_upd;
        row_q <= row_mem[q_reg];
    end

    // Members whose last dominator falls in the current front
    always_comb
    begin
        for (int i = 0; i < MAX_POPULATION; i++)
            new_bits[i] = peel_valid_reg && row_q[i] && (cnt_cell_reg[i] == CNT_W'(1));
    end

    // Count and rank cells
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_POPULATION; i++)
        begin
            if (state_reg == ST_CMP_END && p_reg == IDX_W'(i))
            begin
                cnt_cell_reg[i] <= cnt_upd;
                if (cnt_upd == '0)
                    rank_cell_reg[i] <= CNT_W'(1);
            end
            else if (peel_valid_reg && row_q[i] && cnt_cell_reg[i] != '0)
            begin
                cnt_cell_reg[i] <= cnt_cell_reg[i] - CNT_W'(1);
                if (new_bits[i])
                    rank_cell_reg[i] <= rank_reg + CNT_W'(1);
            end
            else if (state_reg == ST_OUT && out_take)
            begin
                if (i < MAX_POPULATION - 1)
                    rank_cell_reg[i] <= rank_cell_reg[(i + 1) % MAX_POPULATION];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    loaded_next = n_full ? loaded_reg : loaded_reg + CNT_W'(1);
                    if (in_ch.final_member)
                    begin
                        n_next     = loaded_next;
                        p_next     = '0;
                        q_next     = '0;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (q_last)
                    state_next = ST_CMP_END;
                else
                    q_next = q_reg + IDX_W'(1);
            end
            ST_CMP_END:
            begin
                q_next = '0;
                if ({1'b0, p_reg} == n_reg - CNT_W'(1))
                    state_next = ST_PEEL;
                else
                begin
                    p_next     = p_reg + IDX_W'(1);
                    state_next = ST_CMP;
                end
            end
            ST_PEEL:
            begin
                if (q_last)
                    state_next = ST_PEEL_END;
                else
                    q_next = q_reg + IDX_W'(1);
            end
            ST_PEEL_END:
            begin
                q_next = '0;
                if ((next_acc_reg | new_bits) == '0 || rank_reg + CNT_W'(1) >= RANK_LIMIT)
                    state_next = ST_OUT;
                else
                    state_next = ST_PEEL;
            end
            ST_OUT:
            begin
                if (out_take && out_last_idx)
                begin
                    loaded_next = '0;
                    state_next  = ST_LOAD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            loaded_reg     <= '0;
            n_reg          <= '0;
            p_reg          <= '0;
            q_reg          <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_q_reg      <= '0;
            row_reg        <= '0;
            cnt_reg        <= '0;
            peel_valid_reg <= 1'b0;
            front_reg      <= '0;
            next_acc_reg   <= '0;
            rank_reg       <= CNT_W'(1);
            out_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            n_reg          <= n_next;
            p_reg          <= p_next;
            q_reg          <= q_next;
            cmp_valid_reg  <= (state_reg == ST_CMP);
            cmp_q_reg      <= q_reg;
            peel_valid_reg <= (state_reg == ST_PEEL) && front_reg[q_reg];

            // Row and count accumulate over one compare sweep
            if (state_reg == ST_CMP_END)
            begin
                row_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                row_reg <= row_upd;
                cnt_reg <= cnt_upd;
            end

            // Front bookkeeping
            if (state_reg == ST_LOAD)
            begin
                front_reg    <= '0;
                next_acc_reg <= '0;
                rank_reg     <= CNT_W'(1);
            end
            else if (state_reg == ST_CMP_END)
            begin
                if (cnt_upd == '0)
                    front_reg[p_reg] <= 1'b1;
            end
            else if (state_reg == ST_PEEL_END)
            begin
                front_reg    <= next_acc_reg | new_bits;
                next_acc_reg <= '0;
                rank_reg     <= rank_reg + CNT_W'(1);
            end
            else if (state_reg == ST_PEEL)
                next_acc_reg <= next_acc_reg | new_bits;

            // Output register
            if (state_reg == ST_OUT && out_take)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= out_last_idx ? '0 : out_idx_reg + IDX_W'(1);
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_take)
        begin
            out_index_reg <= out_idx_reg;
            out_rank_reg  <= rank_cell_reg[0];
            out_last_reg  <= out_last_idx;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.member_index = out_index_reg;
    assign out_ch.front_rank   = out_rank_reg;
    assign out_ch.last_result  = out_last_reg;

    // Checks
    a_out_has_members: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (n_reg != '0))
        else $error("output phase with empty population");

    a_cmp_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_CMP || state_reg == ST_CMP_END))
        else $error("compare result outside compare sweep");

    a_peel_front: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEEL) |-> (front_reg != '0))
        else $error("peeling an empty front");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEEL) |-> (rank_reg < RANK_LIMIT))
        else $error("rank past limit");

endmodule

`default_nettype wire

// ===== verif/pareto_front_ranker_tb.sv =====
// Self-checking bench for the Pareto front ranker: loads populations, predicts
// front ranks with its own non-dominated sort and checks every result word.
// Depends on pfr_pkg, the pfr_if.sv interfaces and the pareto_front_ranker RTL.
`timescale 1ns / 100ps

module pareto_front_ranker_tb;
    import pfr_pkg::*;

    // One input word plus an optional typed-in rank for the directed table
    typedef struct {
        logic signed [31:0] oa;
        logic signed [31:0] ob;
        logic signed [31:0] oc;
        logic signed [31:0] od;
        bit                 fin;
        int                 known_rank;   // -1: use the predictor only
    } member_row_t;

    typedef struct {
        logic [5:0] idx;
        logic [6:0] rank;
        bit         last;
    } rank_word_t;

    // Watchdog limit, above the worst ranking pass with no handshake
    localparam int WATCHDOG = 40000;

    logic clk;
    logic rst_n;
    pfr_in_if  in_ch ();
    pfr_out_if out_ch ();
    pfr_cfg_if cfg_ch ();

    pareto_front_ranker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_ch(cfg_ch.sink)
    );

    // Predictor state
    logic [31:0] pop_obj [0:63][0:3];
    int          member_total;
    int          obj_used;
    rank_word_t  rank_queue [$];

    int  errors;
    int  results_seen;
    int  populations;
    int  idle_cycles;
    bit  out_no_stall;
    bit  in_no_idle;

    // Directed table: extremes, equal members, single member, trade-off front
    member_row_t directed [10];

    always #1 clk = ~clk;

    // p dominates q over the first obj_used objectives, signed compare
    function automatic bit dominates(int p, int q);
        bit strict;
        strict = 1'b0;
        for (int m = 0; m < obj_used; m++)
        begin
            if ($signed(pop_obj[p][m]) > $signed(pop_obj[q][m]))
                return 1'b0;
            if ($signed(pop_obj[p][m]) < $signed(pop_obj[q][m]))
                strict = 1'b1;
        end
        return strict;
    endfunction

    // Rank the stored population and queue one expected word per member
    task automatic rank_population();
        int         dom_cnt [64];
        bit [63:0]  dom_row [64];
        int         rank_of [64];
        bit [63:0]  front;
        bit [63:0]  next_front;
        int         r;
        rank_word_t w;
        front = '0;
        for (int p = 0; p < member_total; p++)
        begin
            dom_row[p] = '0;
            dom_cnt[p] = 0;
            rank_of[p] = 0;
            for (int q = 0; q < member_total; q++)
            begin
                if (dominates(p, q))
                    dom_row[p][q] = 1'b1;
                else if (dominates(q, p))
                    dom_cnt[p]++;
            end
            if (dom_cnt[p] == 0)
            begin
                rank_of[p] = 1;
                front[p] = 1'b1;
            end
        end
        r = 1;
        while (front != '0 && r < 64)
        begin
            next_front = '0;
            for (int p = 0; p < member_total; p++)
            begin
                if (!front[p])
                    continue;
                for (int q = 0; q < member_total; q++)
                begin
                    if (dom_row[p][q] && dom_cnt[q] > 0)
                    begin
                        dom_cnt[q]--;
                        if (dom_cnt[q] == 0)
                        begin
                            rank_of[q] = r + 1;
                            next_front[q] = 1'b1;
                        end
                    end
                end
            end
            front = next_front;
            r++;
        end
        for (int i = 0; i < member_total; i++)
        begin
            w.idx  = 6'(i);
            w.rank = 7'(rank_of[i]);
            w.last = (i + 1 == member_total);
            rank_queue = {rank_queue, w};
        end
        member_total = 0;
        populations++;
    endtask

    // Model one accepted member word
    task automatic absorb_member(member_row_t m);
        if (member_total < MAX_POPULATION)
        begin
            pop_obj[member_total][0] = m.oa;
            pop_obj[member_total][1] = m.ob;
            pop_obj[member_total][2] = m.oc;
            pop_obj[member_total][3] = m.od;
            member_total++;
        end
        if (m.fin)
            rank_population();
    endtask

    // Drive one member word and wait for acceptance; returns at a falling edge
    // with valid still high, the next call or the caller takes it down
    task automatic send_member(member_row_t m);
        while (!in_no_idle && $urandom_range(99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.objective_a  <= m.oa;
        in_ch.objective_b  <= m.ob;
        in_ch.objective_c  <= m.oc;
        in_ch.objective_d  <= m.od;
        in_ch.final_member <= m.fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        absorb_member(m);
        @(negedge clk);
    endtask

    // Wait until every expected word is in, plus the block's settle time
    task automatic drain();
        int n;
        in_ch.valid <= 1'b0;
        n = 0;
        while (rank_queue.size() != 0 && n < WATCHDOG)
        begin
            @(negedge clk);
            n++;
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic write_obj_count(logic [2:0] v);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.objective_count <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        obj_used = (v == 0) ? 1 : (v > 4 ? 4 : int'(v));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_obj(int spread);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        rank_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (rank_queue.size() == 0)
            begin
                $display("%0t: unexpected word idx=%0d rank=%0d", $time,
                         out_ch.member_index, out_ch.front_rank);
                errors++;
            end
            else
            begin
                w = rank_queue.pop_front();
                if (out_ch.member_index !== w.idx || out_ch.front_rank !== w.rank ||
                    out_ch.last_result !== w.last)
                begin
                    $display("%0t: mismatch exp idx=%0d rank=%0d last=%0d",
                             $time, w.idx, w.rank, w.last);
                    $display("%0t:          got idx=%0d rank=%0d last=%0d",
                             $time, out_ch.member_index, out_ch.front_rank,
                             out_ch.last_result);
                    errors++;
                end
            end
        end
    end

    // Ready generator
    always @(negedge clk)
        out_ch.ready <= out_no_stall || ($urandom_range(99) >= 21);

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        member_row_t m;
        int          n;
        int          typed_rank [64];
        int          typed_n;
        int          qi;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.objective_a = '0;
        in_ch.objective_b = '0;
        in_ch.objective_c = '0;
        in_ch.objective_d = '0;
        in_ch.final_member = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.objective_count = '0;
        populations = 0;
        member_total = 0; obj_used = 2;
        out_no_stall = 1'b0; in_no_idle = 1'b0;
        typed_n = 0;

        directed = '{
            // single member after reset: rank 1
            '{32'sd5, 32'sd5, 32'sd0, 32'sd0, 1'b1, 1},
            // extremes, two objectives: min point first, max point behind both ties
            '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1},
            '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0, 3},
            '{32'hffff_ffff, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 2},
            '{32'hffff_ffff, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 2},
            // trade-off front with a chain behind it
            '{32'sd1, 32'sd9, 32'sd0, 32'sd0, 1'b0, -1},
            '{32'sd9, 32'sd1, 32'sd0, 32'sd0, 1'b0, -1},
            '{32'sd10, 32'sd10, 32'sd0, 32'sd0, 1'b0, -1},
            '{32'sd11, 32'sd11, 32'sd0, 32'sd0, 1'b0, -1},
            '{32'sd12, 32'sd12, 32'sd0, 32'sd0, 1'b1, -1}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Typed-in ranks replace the predicted ones for their population
        foreach (directed[i])
        begin
            typed_rank[typed_n] = directed[i].known_rank;
            typed_n++;
            send_member(directed[i]);
            if (directed[i].fin)
            begin
                for (int j = 0; j < typed_n; j++)
                begin
                    qi = rank_queue.size() - typed_n + j;
                    if (typed_rank[j] > 0)
                    begin
                        if (rank_queue[qi].rank != 7'(typed_rank[j]))
                        begin
                            $display("%0t: predictor exp rank=%0d got rank=%0d", $time,
                                     typed_rank[j], rank_queue[qi].rank);
                            errors++;
                        end
                        rank_queue[qi].rank = 7'(typed_rank[j]);
                    end
                end
                typed_n = 0;
            end
        end
        drain();

        // every objective count incl. zero and saturating values
        for (int oc = 0; oc < 8; oc++)
        begin
            write_obj_count(3'(oc));
            for (int i = 0; i < 6; i++)
            begin
                m = '{rand_obj(4), rand_obj(4), rand_obj(4), rand_obj(4), i == 5, -1};
                send_member(m);
            end
            drain();
        end

        // full population, then dropped members and a dropped final word
        write_obj_count(3'd4);
        for (int i = 0; i < 67; i++)
        begin
            m = '{rand_obj(3), rand_obj(3), rand_obj(3), rand_obj(3), i == 66, -1};
            send_member(m);
        end
        drain();

        // random populations; a no-idle stretch in the middle
        n = 0;
        while (n < 280)
        begin
            int size;
            write_obj_count(3'($urandom_range(1, 4)));
            size = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
            in_no_idle   = (n > 100 && n < 200);
            out_no_stall = in_no_idle;
            for (int i = 0; i < size; i++)
            begin
                m = '{rand_obj(6), rand_obj(6), rand_obj(6), rand_obj(6),
                      i == size - 1, -1};
                send_member(m);
                n++;
            end
            // sender holds off until all ranks are back
            drain();
        end

        drain();
        $display("covered %0d populations, %0d rank words, objective counts 0..7,",
                 populations, results_seen);
        $display("overflow beyond 64 members and signed extremes");
        if (errors == 0 && rank_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_if.sv
hw/rtl/pfr_dom_cmp.sv
hw/rtl/pareto_front_ranker.sv
verif/pareto_front_ranker_tb.sv
